// ----- rtl/bior_pkg.sv -----
// Package for the band interleave offset remapper.
// Holds field widths, order codes, register indexes and the divider sideband type.
// No dependencies.
package bior_pkg;

  localparam int unsigned DIM_W = 16;
  localparam int unsigned OFF_W = 31;
  localparam int unsigned OUT_W = 48;
  localparam int unsigned CFG_IDX_W = 3;

  // Interleave order codes; code three behaves as BSQ
  typedef enum logic [1:0] {
    ORD_BSQ = 2'd0,
    ORD_BIL = 2'd1,
    ORD_BIP = 2'd2,
    ORD_RSV = 2'd3
  } order_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_ORDER = 3'd0,
    REG_DST_ORDER = 3'd1,
    REG_SRC_FAST  = 3'd2,
    REG_SRC_MID   = 3'd3,
    REG_SRC_SLOW  = 3'd4,
    REG_DST_FAST  = 3'd5,
    REG_DST_MID   = 3'd6,
    REG_DST_SLOW  = 3'd7
  } reg_idx_e;

  // Values carried alongside a division
  typedef struct packed {
    logic [DIM_W-1:0] f;
  } side_t;

endpackage

// ----- rtl/band_interleave_offset_remap.sv -----
// Top level of the band interleave offset remapper.
// Depends on bior_pkg, bior_div and bior_recomb.
//
// Converts a linear element offset in a BSQ/BIL/BIP cube into the offset of
// the same element in a cube of another interleave order.
// Input: pulse start_i with source_offset_i; busy_o is always low, so one
// transaction may be started in every cycle.
// Output: valid_o is high for one cycle with dest_offset_o; the receiver
// cannot stall and none is needed.
// Pipeline: two chained 31-stage dividers split the offset into
// fast, middle and slow indices, one stage maps the indices between orders,
// three parallel 31-stage dividers wrap them, and four stages rebuild the
// offset (two multiplies, two adds). Throughput is one offset per cycle,
// set by the one-bit-per-stage divider pipelines.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i; write
// only while the pipeline is empty. A size of zero acts as one; order code
// three acts as BSQ.
// Reset clears the pipeline valid bits and sets both orders to BSQ and all
// sizes to one.
module band_interleave_offset_remap (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [bior_pkg::OFF_W-1:0]     source_offset_i,
  output logic                           valid_o,
  output logic [bior_pkg::OUT_W-1:0]     dest_offset_o,
  input  logic                           cfg_we_i,
  input  logic [bior_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bior_pkg::DIM_W-1:0]     cfg_wdata_i
);

  localparam int unsigned DW = bior_pkg::DIM_W;
  localparam int unsigned NW = bior_pkg::OFF_W;

  bior_pkg::order_e src_ord_q, dst_ord_q;
  logic [DW-1:0] sf_q, sm_q, df_q, dm_q, ds_q;
  logic [DW-1:0] sf, sm, df, dm, ds;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_ord_q <= bior_pkg::ORD_BSQ;
      dst_ord_q <= bior_pkg::ORD_BSQ;
      sf_q      <= DW'(1);
      sm_q      <= DW'(1);
      df_q      <= DW'(1);
      dm_q      <= DW'(1);
      ds_q      <= DW'(1);
    end else if (cfg_we_i) begin
      unique case (bior_pkg::reg_idx_e'(cfg_idx_i))
        bior_pkg::REG_SRC_ORDER: src_ord_q <= bior_pkg::order_e'(cfg_wdata_i[1:0]);
        bior_pkg::REG_DST_ORDER: dst_ord_q <= bior_pkg::order_e'(cfg_wdata_i[1:0]);
        bior_pkg::REG_SRC_FAST:  sf_q <= cfg_wdata_i;
        bior_pkg::REG_SRC_MID:   sm_q <= cfg_wdata_i;
        bior_pkg::REG_DST_FAST:  df_q <= cfg_wdata_i;
        bior_pkg::REG_DST_MID:   dm_q <= cfg_wdata_i;
        bior_pkg::REG_DST_SLOW:  ds_q <= cfg_wdata_i;
        default: ; // source slow size is not needed
      endcase
    end
  end

  // zero size acts as one
  assign sf = (sf_q == '0) ? DW'(1) : sf_q;
  assign sm = (sm_q == '0) ? DW'(1) : sm_q;
  assign df = (df_q == '0) ? DW'(1) : df_q;
  assign dm = (dm_q == '0) ? DW'(1) : dm_q;
  assign ds = (ds_q == '0) ? DW'(1) : ds_q;

  assign busy_o = 1'b0;

  // split: off / Sf, then (off / Sf) / Sm
  logic            v1, v2;
  logic [NW-1:0]   q1, q2;
  logic [DW-1:0]   r1, r2;
  bior_pkg::side_t side0, side1, side2;

  assign side0.f = '0;

  bior_div u_div_fast (
    .clk_i, .rst_ni,
    .valid_i (start_i),
    .num_i   (source_offset_i),
    .den_i   (sf),
    .side_i  (side0),
    .valid_o (v1),
    .quot_o  (q1),
    .rem_o   (r1),
    .side_o  ()
  );

  assign side1.f = r1;

  bior_div u_div_mid (
    .clk_i, .rst_ni,
    .valid_i (v1),
    .num_i   (q1),
    .den_i   (sm),
    .side_i  (side1),
    .valid_o (v2),
    .quot_o  (q2),
    .rem_o   (r2),
    .side_o  (side2)
  );

  // order mapping: storage indices to x/y/z, then to destination slots
  logic [NW-1:0] fi, mi, x, y, z, a_d, b_d, c_d;
  logic [NW-1:0] a_q, b_q, c_q;
  logic          vm_q;

  assign fi = NW'(side2.f);
  assign mi = NW'(r2);

  always_comb begin
    unique case (src_ord_q)
      bior_pkg::ORD_BIL: begin x = fi; z = mi; y = q2; end
      bior_pkg::ORD_BIP: begin z = fi; x = mi; y = q2; end
      default:           begin x = fi; y = mi; z = q2; end
    endcase
    unique case (dst_ord_q)
      bior_pkg::ORD_BIL: begin a_d = x; b_d = z; c_d = y; end
      bior_pkg::ORD_BIP: begin a_d = z; b_d = x; c_d = y; end
      default:           begin a_d = x; b_d = y; c_d = z; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= 1'b0;
    end else begin
      vm_q <= v2;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    c_q <= c_d;
  end

  // wrap each slot modulo its destination size
  logic          va, vb, vc;
  logic [DW-1:0] ra, rb, rc;

  bior_div u_wrap_a (
    .clk_i, .rst_ni,
    .valid_i (vm_q), .num_i (a_q), .den_i (df), .side_i (side0),
    .valid_o (va), .quot_o (), .rem_o (ra), .side_o ()
  );

  bior_div u_wrap_b (
    .clk_i, .rst_ni,
    .valid_i (vm_q), .num_i (b_q), .den_i (dm), .side_i (side0),
    .valid_o (vb), .quot_o (), .rem_o (rb), .side_o ()
  );

  bior_div u_wrap_c (
    .clk_i, .rst_ni,
    .valid_i (vm_q), .num_i (c_q), .den_i (ds), .side_i (side0),
    .valid_o (vc), .quot_o (), .rem_o (rc), .side_o ()
  );

  // rebuild destination offset
  bior_recomb u_recomb (
    .clk_i, .rst_ni,
    .valid_i (va & vb & vc),
    .a_i     (ra),
    .b_i     (rb),
    .c_i     (rc),
    .df_i    (df),
    .dm_i    (dm),
    .valid_o (valid_o),
    .dest_o  (dest_offset_o)
  );

endmodule

// ----- rtl/bior_div.sv -----
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on bior_pkg. Divisor must be non-zero and stable while items are in flight.
module bior_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic [bior_pkg::OFF_W-1:0] num_i,
  input  logic [bior_pkg::DIM_W-1:0] den_i,
  input  bior_pkg::side_t           side_i,
  output logic                      valid_o,
  output logic [bior_pkg::OFF_W-1:0] quot_o,
  output logic [bior_pkg::DIM_W-1:0] rem_o,
  output bior_pkg::side_t           side_o
);

  localparam int unsigned NW = bior_pkg::OFF_W;
  localparam int unsigned DW = bior_pkg::DIM_W;

  // stage i holds the state after i+1 quotient bits
  logic            vld_q  [NW];
  logic [NW-1:0]   num_q  [NW];
  logic [DW-1:0]   rem_q  [NW];
  bior_pkg::side_t side_q [NW];

  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic            vld_in;
    logic [NW-1:0]   num_in;
    logic [DW-1:0]   rem_in;
    bior_pkg::side_t side_in;
    logic [DW:0]     trial;
    logic            ge;

    // stage input: the ports for the first stage, the previous stage otherwise
    if (i == 0) begin : g_first
      assign vld_in  = valid_i;
      assign num_in  = num_i;
      assign rem_in  = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[i-1];
      assign num_in  = num_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign side_in = side_q[i-1];
    end

    // shift next dividend bit into the partial remainder and try a subtract
    assign trial = {rem_in, num_in[NW-1]};
    assign ge    = trial >= {1'b0, den_i};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[i]  <= ge ? DW'(trial - {1'b0, den_i}) : trial[DW-1:0];
      num_q[i]  <= {num_in[NW-2:0], ge};
      side_q[i] <= side_in;
    end
  end

  assign valid_o = vld_q[NW-1];
  assign quot_o  = num_q[NW-1];
  assign rem_o   = rem_q[NW-1];
  assign side_o  = side_q[NW-1];

endmodule

// ----- rtl/bior_recomb.sv -----
// Rebuilds the destination offset f + Df*(m + Dm*s) over four register stages.
// Depends on bior_pkg.
module bior_recomb (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [bior_pkg::DIM_W-1:0] a_i,
  input  logic [bior_pkg::DIM_W-1:0] b_i,
  input  logic [bior_pkg::DIM_W-1:0] c_i,
  input  logic [bior_pkg::DIM_W-1:0] df_i,
  input  logic [bior_pkg::DIM_W-1:0] dm_i,
  output logic                       valid_o,
  output logic [bior_pkg::OUT_W-1:0] dest_o
);

  localparam int unsigned DW = bior_pkg::DIM_W;

  logic [3:0]        vld_q;
  logic [DW-1:0]     a1_q, a2_q, a3_q, b1_q;
  logic [2*DW-1:0]   p1_q;
  logic [2*DW:0]     t_q;
  logic [3*DW:0]     p2_q;
  logic [bior_pkg::OUT_W-1:0] out_q;
  logic [3*DW:0]     sum_d;

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  assign sum_d = p2_q + (3*DW+1)'(a3_q);

  // multiply, add, multiply, add
  always_ff @(posedge clk_i) begin
    p1_q  <= dm_i * c_i;
    a1_q  <= a_i;
    b1_q  <= b_i;
    t_q   <= (2*DW+1)'(p1_q) + (2*DW+1)'(b1_q);
    a2_q  <= a1_q;
    p2_q  <= (3*DW+1)'(df_i) * (3*DW+1)'(t_q);
    a3_q  <= a2_q;
    out_q <= sum_d[bior_pkg::OUT_W-1:0];
  end

  assign valid_o = vld_q[3];
  assign dest_o  = out_q;

endmodule

// ----- tb/testbench.sv -----
// Testbench for band_interleave_offset_remap: drives offsets through the
// remapper under several cube geometries and checks every result in order.
// Depends on bior_pkg and the band_interleave_offset_remap RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned DIM_W     = bior_pkg::DIM_W;
  localparam int unsigned OFF_W     = bior_pkg::OFF_W;
  localparam int unsigned OUT_W     = bior_pkg::OUT_W;
  localparam int unsigned CFG_IDX_W = bior_pkg::CFG_IDX_W;

  // Predicts remapped offsets and checks them in arrival order
  class remap_scoreboard;
    logic [1:0]       src_ord, dst_ord;
    logic [DIM_W-1:0] sz [8];
    logic [OUT_W-1:0] pending_q [$];
    int               errors;

    function void reset_regs();
      src_ord = bior_pkg::ORD_BSQ;
      dst_ord = bior_pkg::ORD_BSQ;
      foreach (sz[i]) sz[i] = 1;
      pending_q.delete();
      errors = 0;
    endfunction

    function void write_reg(bior_pkg::reg_idx_e idx, logic [DIM_W-1:0] val);
      case (idx)
        bior_pkg::REG_SRC_ORDER: src_ord = val[1:0];
        bior_pkg::REG_DST_ORDER: dst_ord = val[1:0];
        default:                 sz[idx] = val;
      endcase
    endfunction

    function logic [63:0] dim(int i);
      return (sz[i] == 0) ? 64'd1 : 64'(sz[i]);
    endfunction

    // Work out the destination offset for one accepted source offset
    function void note_offset(logic [OFF_W-1:0] src);
      logic [63:0] off, sf, sm, df, dm, ds, plane, f, m, s, x, y, z, a, b, c, r;
      off = 64'(src);
      sf = dim(bior_pkg::REG_SRC_FAST); sm = dim(bior_pkg::REG_SRC_MID);
      df = dim(bior_pkg::REG_DST_FAST); dm = dim(bior_pkg::REG_DST_MID);
      ds = dim(bior_pkg::REG_DST_SLOW);
      plane = sf * sm;
      f = off % sf;
      m = (off % plane) / sf;
      s = off / plane;
      case (src_ord)
        bior_pkg::ORD_BIL: begin x = f; z = m; y = s; end
        bior_pkg::ORD_BIP: begin z = f; x = m; y = s; end
        default:           begin x = f; y = m; z = s; end
      endcase
      case (dst_ord)
        bior_pkg::ORD_BIL: begin a = x; b = z; c = y; end
        bior_pkg::ORD_BIP: begin a = z; b = x; c = y; end
        default:           begin a = x; b = y; c = z; end
      endcase
      a = a % df; b = b % dm; c = c % ds;
      r = a + df * (b + dm * c);
      pending_q.push_back(r[OUT_W-1:0]);
    endfunction

    function void check_result(logic [OUT_W-1:0] got);
      logic [OUT_W-1:0] exp_off;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0h", $time, got);
        errors++;
        return;
      end
      exp_off = pending_q.pop_front();
      if (got !== exp_off) begin
        $display("%0t: dest_offset mismatch, expected %0h, actual %0h",
                 $time, exp_off, got);
        errors++;
      end
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start_i = 1'b0;
  logic             busy_o;
  logic [OFF_W-1:0] source_offset_i = '0;
  logic             valid_o;
  logic [OUT_W-1:0] dest_offset_o;
  logic             cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [DIM_W-1:0] cfg_wdata_i = '0;

  remap_scoreboard sb = new();
  int idle_pct;

  always #1 clk_i = ~clk_i;

  band_interleave_offset_remap uut (.*);

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) sb.check_result(dest_offset_o);
  end

  // Register write while idle
  task automatic write_cfg(bior_pkg::reg_idx_e idx, logic [DIM_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // One offset transaction, with a random gap before it
  task automatic send_offset(logic [OFF_W-1:0] off);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i <= 1'b1;
    source_offset_i <= off;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sb.note_offset(off);
  endtask

  task automatic drain();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic logic [OFF_W-1:0] rand_offset();
    case ($urandom_range(3))
      0: return OFF_W'($urandom_range(4095));
      1: return '1 - OFF_W'($urandom_range(15));
      default: return OFF_W'($urandom);
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] rand_size();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return DIM_W'($urandom_range(1, 4));
      default: return DIM_W'($urandom);
    endcase
  endfunction

  task automatic random_geometry();
    write_cfg(bior_pkg::REG_SRC_ORDER, DIM_W'($urandom_range(3)));
    write_cfg(bior_pkg::REG_DST_ORDER, DIM_W'($urandom_range(3)));
    for (int r = bior_pkg::REG_SRC_FAST; r <= bior_pkg::REG_DST_SLOW; r++)
      write_cfg(bior_pkg::reg_idx_e'(r), rand_size());
  endtask

  initial begin
    #100000;
    $display("FAIL band_interleave_offset_remap");
    $finish;
  end

  initial begin
    sb.reset_regs();
    idle_pct = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset geometry, then every order pair, each with one mix of small, zero and full sizes
    send_offset('0);
    send_offset('1);
    for (int so = 0; so < 4; so++) begin
      for (int d = 0; d < 4; d++) begin
        drain();
        write_cfg(bior_pkg::REG_SRC_ORDER, DIM_W'(so));
        write_cfg(bior_pkg::REG_DST_ORDER, DIM_W'(d));
        write_cfg(bior_pkg::REG_SRC_FAST, (d == 3) ? '0 : DIM_W'(5));
        write_cfg(bior_pkg::REG_SRC_MID, DIM_W'(7));
        write_cfg(bior_pkg::REG_SRC_SLOW, '1);
        write_cfg(bior_pkg::REG_DST_FAST, (so == 3) ? '1 : DIM_W'(3));
        write_cfg(bior_pkg::REG_DST_MID, (so == 2) ? '0 : DIM_W'(9));
        write_cfg(bior_pkg::REG_DST_SLOW, (d == 2) ? '1 : DIM_W'(4));
        send_offset(OFF_W'(so * 37 + d));
      end
    end
    // Widest geometry, largest offset: exercises the widest results
    drain();
    for (int r = bior_pkg::REG_SRC_FAST; r <= bior_pkg::REG_DST_SLOW; r++)
      write_cfg(bior_pkg::reg_idx_e'(r), '1);
    send_offset('1);
    send_offset(OFF_W'(32'h5555_5555));

    // Random phases with changing idle rate
    for (int ph = 0; ph < 36; ph++) begin
      idle_pct = (ph < 12) ? 26 : (ph < 24) ? 74 : 0;
      drain();
      random_geometry();
      for (int i = 0; i < 50; i++) send_offset(rand_offset());
    end

    drain();
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("PASS band_interleave_offset_remap");
    end else begin
      $display("FAIL band_interleave_offset_remap");
    end
    $finish;
  end

endmodule
